FILE: rtl/lccn_pkg.sv
// Shared constants, types and helpers for the card number classifier.
package lccn_pkg;

  localparam int unsigned CardNumW = 63;
  localparam int unsigned NumDigits = 19;
  localparam int unsigned DigitW = 4;
  localparam int unsigned BcdW = NumDigits * DigitW;
  localparam int unsigned ShiftCntW = $clog2(CardNumW);
  localparam int unsigned IdxW = $clog2(NumDigits);
  localparam int unsigned CountW = 5;

  localparam logic [DigitW-1:0] Radix = 4'd10;
  localparam logic [CountW-1:0] AmexLen = 5'd15;
  localparam logic [CountW-1:0] LongLen = 5'd16;
  localparam logic [CountW-1:0] ShortLen = 5'd13;
  localparam logic [DigitW-1:0] AmexSecondB = 4'd7;

  typedef enum logic [1:0] {
    KIND_INVALID    = 2'd0,
    KIND_AMEX       = 2'd1,
    KIND_MASTERCARD = 2'd2,
    KIND_VISA       = 2'd3
  } card_kind_e;

  typedef struct packed {
    card_kind_e         kind;
    logic               ok;
    logic [CountW-1:0]  count;
  } lccn_res_t;

  // Luhn doubling: 2d, folded to its digit sum when it reaches ten.
  function automatic logic [DigitW-1:0] dbl_digit(input logic [DigitW-1:0] d);
    logic [DigitW:0] t;
    t = {d, 1'b0};
    if (t >= {1'b0, Radix}) begin
      t = t - 5'd9;
    end
    return t[DigitW-1:0];
  endfunction

endpackage

FILE: rtl/lccn_if.sv
// Request and result channel interfaces of the card number classifier.
interface lccn_in_if;
  import lccn_pkg::*;
  logic                valid;
  logic                ready;
  logic [CardNumW-1:0] card_number;

  modport source (output valid, output card_number, input ready);
  modport sink (input valid, input card_number, output ready);
endinterface

interface lccn_out_if;
  import lccn_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        card_kind;
  logic              luhn_ok;
  logic [CountW-1:0] digit_count;

  modport source (output valid, output card_kind, output luhn_ok, output digit_count,
                  input ready);
  modport sink (input valid, input card_kind, input luhn_ok, input digit_count,
                output ready);
endinterface

FILE: rtl/lccn_bcd.sv
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
module lccn_bcd (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [lccn_pkg::CardNumW-1:0] bin_i,
  output logic                          done_o,
  output logic [lccn_pkg::BcdW-1:0]     bcd_o
);
  import lccn_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [ShiftCntW-1:0] cnt_q, cnt_d;
  logic [CardNumW-1:0]  bin_q, bin_d;
  logic [BcdW-1:0]      bcd_q, bcd_d;
  logic [BcdW-1:0]      adj;

  // Add 3 to every digit of 5 or more before the shift.
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_q[i*DigitW +: DigitW] >= 4'd5) begin
        adj[i*DigitW +: DigitW] = bcd_q[i*DigitW +: DigitW] + 4'd3;
      end else begin
        adj[i*DigitW +: DigitW] = bcd_q[i*DigitW +: DigitW];
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      bin_d  = bin_i;
      bcd_d  = '0;
    end else if (busy_q) begin
      bcd_d = {adj[BcdW-2:0], bin_q[CardNumW-1]};
      bin_d = {bin_q[CardNumW-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == ShiftCntW'(CardNumW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

FILE: rtl/lccn_luhn.sv
// Digit-serial Luhn checksum, digit count and brand classification.
module lccn_luhn (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [lccn_pkg::BcdW-1:0] bcd_i,
  output logic                      done_o,
  output lccn_pkg::lccn_res_t       res_o
);
  import lccn_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [BcdW-1:0]   dig_q, dig_d;
  logic [DigitW-1:0] sum_q, sum_d;
  logic [DigitW-1:0] prev_q, prev_d;
  logic [DigitW-1:0] first_q, first_d;
  logic [DigitW-1:0] second_q, second_d;
  logic [CountW-1:0] count_q, count_d;
  logic [DigitW-1:0] cur, term;
  logic [DigitW:0]   sum_raw;

  assign cur     = dig_q[DigitW-1:0];
  assign term    = idx_q[0] ? dbl_digit(cur) : cur;
  assign sum_raw = {1'b0, sum_q} + {1'b0, term};

  always_comb begin
    busy_d   = busy_q;
    done_d   = 1'b0;
    idx_d    = idx_q;
    dig_d    = dig_q;
    sum_d    = sum_q;
    prev_d   = prev_q;
    first_d  = first_q;
    second_d = second_q;
    count_d  = count_q;
    if (start_i) begin
      busy_d   = 1'b1;
      idx_d    = '0;
      dig_d    = bcd_i;
      sum_d    = '0;
      prev_d   = '0;
      first_d  = '0;
      second_d = '0;
      count_d  = '0;
    end else if (busy_q) begin
      // checksum kept modulo ten
      if (sum_raw >= {1'b0, Radix}) begin
        sum_d = DigitW'(sum_raw - {1'b0, Radix});
      end else begin
        sum_d = sum_raw[DigitW-1:0];
      end
      // highest non-zero digit so far sets the length and leading pair
      if (cur != '0) begin
        count_d  = CountW'(idx_q) + 1'b1;
        first_d  = cur;
        second_d = prev_q;
      end
      prev_d = cur;
      dig_d  = {{DigitW{1'b0}}, dig_q[BcdW-1:DigitW]};
      idx_d  = idx_q + 1'b1;
      if (idx_q == IdxW'(NumDigits - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
      idx_q    <= '0;
      sum_q    <= '0;
      count_q  <= '0;
    end else begin
      busy_q   <= busy_d;
      done_q   <= done_d;
      idx_q    <= idx_d;
      sum_q    <= sum_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q    <= dig_d;
    prev_q   <= prev_d;
    first_q  <= first_d;
    second_q <= second_d;
  end

  always_comb begin
    res_o.count = count_q;
    res_o.ok    = (count_q != '0) && (sum_q == '0);
    res_o.kind  = KIND_INVALID;
    if (res_o.ok && count_q >= 5'd2) begin
      if (count_q == AmexLen && first_q == 4'd3 &&
          (second_q == 4'd4 || second_q == AmexSecondB)) begin
        res_o.kind = KIND_AMEX;
      end else if (count_q == LongLen && first_q == 4'd5 &&
                   (second_q inside {[4'd1:4'd5]})) begin
        res_o.kind = KIND_MASTERCARD;
      end else if (first_q == 4'd4 && (count_q == ShortLen || count_q == LongLen)) begin
        res_o.kind = KIND_VISA;
      end
    end
  end

  assign done_o = done_q;

`ifndef ASSERT_OFF
  a_sum_mod10: assert property (@(posedge clk_i) disable iff (!rst_ni) sum_q < Radix)
    else $error("luhn sum left modulo-ten range");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(NumDigits))
    else $error("digit count beyond largest length");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q))
    else $error("luhn done without a finished scan");
`endif

endmodule

FILE: rtl/luhn_card_number_classifier_top.sv
// Top level: card number to decimal, Luhn check and brand classification.
//
// Each request carries one 63-bit binary card number and yields exactly one
// result: card_kind (0 invalid, 1 amex, 2 mastercard, 3 visa), luhn_ok and
// digit_count. One request is worked on at a time. From acceptance it passes
// through the bit-serial binary to BCD converter (one input bit per
// cycle through a shift-and-add-3 register) and then the Luhn unit
// (one decimal digit per cycle, least significant first). The result sits
// in an output register, and in_i.ready rises again in the same cycle that
// the result appears there; the next request is taken while an earlier
// result still waits on out_o.ready. If a finished result finds that
// register still full, the block holds it until the register frees. Zero
// gives an invalid result with luhn_ok low and digit_count zero.
module luhn_card_number_classifier_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  lccn_in_if.sink    in_i,
  lccn_out_if.source out_o
);
  import lccn_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_HOLD = 2'd3;

  logic [1:0]        state_q, state_d;
  logic              out_valid_q, out_valid_d;
  card_kind_e        kind_q, kind_d;
  logic              ok_q, ok_d;
  logic [CountW-1:0] count_q, count_d;

  logic              req_acc;
  logic              bcd_done;
  logic [BcdW-1:0]   bcd;
  logic              luhn_done;
  lccn_res_t         res;
  logic              out_free;
  logic              load;

  assign in_i.ready = (state_q == ST_IDLE);
  assign req_acc    = in_i.valid && in_i.ready;
  // output register can take a new result this cycle
  assign out_free   = !out_valid_q || out_o.ready;
  assign load       = ((state_q == ST_SCAN && luhn_done) || state_q == ST_HOLD) && out_free;

  lccn_bcd u_bcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (req_acc),
    .bin_i   (in_i.card_number),
    .done_o  (bcd_done),
    .bcd_o   (bcd)
  );

  lccn_luhn u_luhn (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (bcd_done),
    .bcd_i   (bcd),
    .done_o  (luhn_done),
    .res_o   (res)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_acc) begin
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        if (bcd_done) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (luhn_done) begin
          state_d = out_free ? ST_IDLE : ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // result register: loaded from the Luhn unit, which holds its result
  always_comb begin
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    ok_d        = ok_q;
    count_d     = count_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
      kind_d      = res.kind;
      ok_d        = res.ok;
      count_d     = res.count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    ok_q    <= ok_d;
    count_q <= count_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.card_kind   = kind_q;
  assign out_o.luhn_ok     = ok_q;
  assign out_o.digit_count = count_q;

`ifndef ASSERT_OFF
  a_req_starts_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> state_q == ST_CONV)
    else $error("accepted request did not start conversion");
  a_bcd_done_in_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bcd_done |-> state_q == ST_CONV)
    else $error("conversion finished outside conversion phase");
  a_luhn_done_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    luhn_done |-> state_q == ST_SCAN)
    else $error("luhn scan finished outside scan phase");
  a_ok_zero_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && count_q == '0 |-> !ok_q && kind_q == KIND_INVALID)
    else $error("zero-digit result marked valid");
`endif

endmodule
